/* design/chm_pkg.sv */
// ---------------------------------------------------------------------------
// chm_pkg: shared types and constants of the charged hadron multiplicity cut
// Field widths, register indexes, the microcode of the shared multiplier
// and the control bundle between sequencer and datapath.
// ---------------------------------------------------------------------------
package chm_pkg;

    // Table size
    localparam int MAX_SLOTS       = 4;
    localparam int DEF_TABLE_SLOTS = 4;

    // Field widths
    localparam int COMP_W  = 24;
    localparam int CODE_W  = 32;
    localparam int NRG_W   = 24;
    localparam int COS_W   = 17;
    localparam int CNT_W   = 8;
    localparam int SLOT_W  = 56;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    localparam logic [REG_IDX_W-1:0] REG_COS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX = 3'd6;

    localparam logic [COS_W-1:0] COS_ONE       = 17'h10000;
    localparam logic [CNT_W-1:0] CNT_SAT       = 8'hFF;
    localparam logic [CNT_W-1:0] MAX_COUNT_RST = 8'hFF;

    // Datapath widths
    localparam int CHUNK_W = 24;
    localparam int OPND_W  = 25;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 128;
    localparam int DOT_W   = 49;
    localparam int SQ_W    = 48;
    localparam int C2_W    = 33;
    localparam int WIDE_W  = 96;

    // Microcode length
    localparam int NUM_STEPS = 26;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic [NRG_W-1:0]         thr;
    } t_slot;

    typedef struct packed {
        logic [COS_W-1:0] cos_limit;
        logic [CNT_W-1:0] min_count;
        logic [CNT_W-1:0] max_count;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_ZERO, OP_PX, OP_PY, OP_PZ, OP_LX, OP_LY, OP_LZ, OP_C,
        OP_DL, OP_DH, OP_P0, OP_P1, OP_L0, OP_L1,
        OP_Q0, OP_Q1, OP_Q2, OP_Q3, OP_C20, OP_C21
    } t_opnd;

    typedef enum logic [2:0] {
        DST_NONE, DST_DOT, DST_PP, DST_LL, DST_C2, DST_Q, DST_LHS
    } t_dest;

    typedef struct packed {
        t_opnd      a;
        t_opnd      b;
        logic [2:0] shift;
        logic       clr;
        t_dest      dest;
    } t_uop;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] step;
    } t_dp_ctrl;

    typedef enum logic [2:0] {
        S_IDLE, S_CALC, S_DRAIN, S_CMP, S_DONE
    } t_state;

    function automatic t_uop mk_uop(input t_opnd a, input t_opnd b, input logic [2:0] shift,
                                    input logic clr, input t_dest dest);
        t_uop u;
        u.a     = a;
        u.b     = b;
        u.shift = shift;
        u.clr   = clr;
        u.dest  = dest;
        return u;
    endfunction

    // Microcode: squares, dot product, then the three wide products in 24-bit chunks
    function automatic t_uop uop_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = mk_uop(OP_C,   OP_C,   3'd0, 1'b1, DST_C2);
            5'd1:  u = mk_uop(OP_PX,  OP_PX,  3'd0, 1'b1, DST_NONE);
            5'd2:  u = mk_uop(OP_PY,  OP_PY,  3'd0, 1'b0, DST_NONE);
            5'd3:  u = mk_uop(OP_PZ,  OP_PZ,  3'd0, 1'b0, DST_PP);
            5'd4:  u = mk_uop(OP_LX,  OP_LX,  3'd0, 1'b1, DST_NONE);
            5'd5:  u = mk_uop(OP_LY,  OP_LY,  3'd0, 1'b0, DST_NONE);
            5'd6:  u = mk_uop(OP_LZ,  OP_LZ,  3'd0, 1'b0, DST_LL);
            5'd7:  u = mk_uop(OP_PX,  OP_LX,  3'd0, 1'b1, DST_NONE);
            5'd8:  u = mk_uop(OP_PY,  OP_LY,  3'd0, 1'b0, DST_NONE);
            5'd9:  u = mk_uop(OP_PZ,  OP_LZ,  3'd0, 1'b0, DST_DOT);
            5'd10: u = mk_uop(OP_P0,  OP_L0,  3'd0, 1'b1, DST_NONE);
            5'd11: u = mk_uop(OP_P0,  OP_L1,  3'd1, 1'b0, DST_NONE);
            5'd12: u = mk_uop(OP_P1,  OP_L0,  3'd1, 1'b0, DST_NONE);
            5'd13: u = mk_uop(OP_P1,  OP_L1,  3'd2, 1'b0, DST_Q);
            5'd14: u = mk_uop(OP_DL,  OP_DL,  3'd0, 1'b1, DST_NONE);
            5'd15: u = mk_uop(OP_DL,  OP_DH,  3'd1, 1'b0, DST_NONE);
            5'd16: u = mk_uop(OP_DH,  OP_DL,  3'd1, 1'b0, DST_NONE);
            5'd17: u = mk_uop(OP_DH,  OP_DH,  3'd2, 1'b0, DST_LHS);
            5'd18: u = mk_uop(OP_Q0,  OP_C20, 3'd0, 1'b1, DST_NONE);
            5'd19: u = mk_uop(OP_Q0,  OP_C21, 3'd1, 1'b0, DST_NONE);
            5'd20: u = mk_uop(OP_Q1,  OP_C20, 3'd1, 1'b0, DST_NONE);
            5'd21: u = mk_uop(OP_Q1,  OP_C21, 3'd2, 1'b0, DST_NONE);
            5'd22: u = mk_uop(OP_Q2,  OP_C20, 3'd2, 1'b0, DST_NONE);
            5'd23: u = mk_uop(OP_Q2,  OP_C21, 3'd3, 1'b0, DST_NONE);
            5'd24: u = mk_uop(OP_Q3,  OP_C20, 3'd3, 1'b0, DST_NONE);
            5'd25: u = mk_uop(OP_Q3,  OP_C21, 3'd4, 1'b0, DST_NONE);
            default: u = mk_uop(OP_ZERO, OP_ZERO, 3'd0, 1'b0, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

/* design/chm_ifs.sv */
// ---------------------------------------------------------------------------
// chm_ifs: request and report channels
// Valid/ready channels carrying one particle request and one event report.
// ---------------------------------------------------------------------------
interface chm_in_if;
    import chm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     has_particle;
    logic                     last_in_event;
    logic signed [CODE_W-1:0] particle_code;
    logic [NRG_W-1:0]         total_energy;
    logic [NRG_W-1:0]         rest_mass;
    logic signed [COMP_W-1:0] mom_x;
    logic signed [COMP_W-1:0] mom_y;
    logic signed [COMP_W-1:0] mom_z;
    logic signed [COMP_W-1:0] lepton_x;
    logic signed [COMP_W-1:0] lepton_y;
    logic signed [COMP_W-1:0] lepton_z;

    modport source (
        output valid, has_particle, last_in_event, particle_code, total_energy, rest_mass,
               mom_x, mom_y, mom_z, lepton_x, lepton_y, lepton_z,
        input  ready
    );
    modport sink (
        input  valid, has_particle, last_in_event, particle_code, total_energy, rest_mass,
               mom_x, mom_y, mom_z, lepton_x, lepton_y, lepton_z,
        output ready
    );
endinterface

interface chm_out_if;
    import chm_pkg::*;

    logic             valid;
    logic             ready;
    logic             passes;
    logic [CNT_W-1:0] multiplicity;

    modport source (output valid, passes, multiplicity, input ready);
    modport sink (input valid, passes, multiplicity, output ready);
endinterface

/* design/chm_regs.sv */
// ---------------------------------------------------------------------------
// chm_regs: configuration register file
// APB-style slave holding the threshold table, cosine limit and count window.
// ---------------------------------------------------------------------------
module chm_regs #(
    parameter int TABLE_SLOTS = chm_pkg::DEF_TABLE_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [chm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [chm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [chm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output chm_pkg::t_slot                  o_slots [TABLE_SLOTS],
    output chm_pkg::t_cfg                   o_cfg
);
    import chm_pkg::*;

    logic [SLOT_W-1:0]    r_slot [TABLE_SLOTS];
    logic [COS_W-1:0]     r_cos;
    logic [CNT_W-1:0]     r_min;
    logic [CNT_W-1:0]     r_max;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[CFG_ADDR_W-1:REG_LSB];

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
            r_cos <= '0;
            r_min <= '0;
            r_max <= MAX_COUNT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_COS: r_cos <= pwdata[COS_W-1:0];
                REG_MIN: r_min <= pwdata[CNT_W-1:0];
                REG_MAX: r_max <= pwdata[CNT_W-1:0];
                default: begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (w_idx == REG_IDX_W'(i)) begin
                            r_slot[i] <= pwdata[SLOT_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_COS: prdata = CFG_DATA_W'(r_cos);
            REG_MIN: prdata = CFG_DATA_W'(r_min);
            REG_MAX: prdata = CFG_DATA_W'(r_max);
            default: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (w_idx == REG_IDX_W'(i)) begin
                        prdata = CFG_DATA_W'(r_slot[i]);
                    end
                end
            end
        endcase
    end

    // Unpack slots: code above, threshold below
    always_comb begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            o_slots[i].code = r_slot[i][SLOT_W-1:NRG_W];
            o_slots[i].thr  = r_slot[i][NRG_W-1:0];
        end
    end

    assign o_cfg.cos_limit = r_cos;
    assign o_cfg.min_count = r_min;
    assign o_cfg.max_count = r_max;

endmodule

/* design/chm_mac.sv */
// ---------------------------------------------------------------------------
// chm_mac: shared multiply-accumulate datapath
// One 25x25 signed multiplier and a 128-bit accumulator run the microcode
// that forms dot^2 and c^2 * |p|^2 * |mu|^2 for the angle test.
// ---------------------------------------------------------------------------
module chm_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  chm_pkg::t_dp_ctrl                i_ctrl,
    input  logic signed [chm_pkg::COMP_W-1:0] i_mom_x,
    input  logic signed [chm_pkg::COMP_W-1:0] i_mom_y,
    input  logic signed [chm_pkg::COMP_W-1:0] i_mom_z,
    input  logic signed [chm_pkg::COMP_W-1:0] i_lepton_x,
    input  logic signed [chm_pkg::COMP_W-1:0] i_lepton_y,
    input  logic signed [chm_pkg::COMP_W-1:0] i_lepton_z,
    input  logic [chm_pkg::COS_W-1:0]        i_cos_limit,
    output logic                             o_angle_ok
);
    import chm_pkg::*;

    // Captured vectors
    logic signed [COMP_W-1:0] r_px, r_py, r_pz, r_lx, r_ly, r_lz;

    // Pipeline between multiplier and accumulator
    logic                     r_pvalid;
    t_uop                     r_puop;
    logic signed [PROD_W-1:0] r_prod;

    // Accumulator and stored partial results
    logic [ACC_W-1:0]  r_acc;
    logic [DOT_W-1:0]  r_dot;
    logic [SQ_W-1:0]   r_pp;
    logic [SQ_W-1:0]   r_ll;
    logic [C2_W-1:0]   r_c2;
    logic [WIDE_W-1:0] r_q;
    logic [WIDE_W-1:0] r_lhs;

    logic [ACC_W-1:0]         n_acc;
    t_uop                     w_uop;
    logic [COS_W-1:0]         w_cos;
    logic signed [OPND_W-1:0] w_opa, w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_prod_ext;
    logic [ACC_W-1:0]         w_addend;

    // Limits above one act as one
    assign w_cos = (i_cos_limit > COS_ONE) ? COS_ONE : i_cos_limit;
    assign w_uop = uop_rom(i_ctrl.step);

    function automatic logic signed [OPND_W-1:0] pick(input t_opnd sel);
        logic signed [OPND_W-1:0] v;
        case (sel)
            OP_PX:   v = {r_px[COMP_W-1], r_px};
            OP_PY:   v = {r_py[COMP_W-1], r_py};
            OP_PZ:   v = {r_pz[COMP_W-1], r_pz};
            OP_LX:   v = {r_lx[COMP_W-1], r_lx};
            OP_LY:   v = {r_ly[COMP_W-1], r_ly};
            OP_LZ:   v = {r_lz[COMP_W-1], r_lz};
            OP_C:    v = {{(OPND_W-COS_W){1'b0}}, w_cos};
            OP_DL:   v = {1'b0, r_dot[CHUNK_W-1:0]};
            OP_DH:   v = r_dot[DOT_W-1:CHUNK_W];
            OP_P0:   v = {1'b0, r_pp[CHUNK_W-1:0]};
            OP_P1:   v = {1'b0, r_pp[2*CHUNK_W-1:CHUNK_W]};
            OP_L0:   v = {1'b0, r_ll[CHUNK_W-1:0]};
            OP_L1:   v = {1'b0, r_ll[2*CHUNK_W-1:CHUNK_W]};
            OP_Q0:   v = {1'b0, r_q[CHUNK_W-1:0]};
            OP_Q1:   v = {1'b0, r_q[2*CHUNK_W-1:CHUNK_W]};
            OP_Q2:   v = {1'b0, r_q[3*CHUNK_W-1:2*CHUNK_W]};
            OP_Q3:   v = {1'b0, r_q[4*CHUNK_W-1:3*CHUNK_W]};
            OP_C20:  v = {1'b0, r_c2[CHUNK_W-1:0]};
            OP_C21:  v = {{(OPND_W-C2_W+CHUNK_W){1'b0}}, r_c2[C2_W-1:CHUNK_W]};
            default: v = '0;
        endcase
        return v;
    endfunction

    // Select operands and multiply
    always_comb begin
        w_opa  = pick(w_uop.a);
        w_opb  = pick(w_uop.b);
        w_prod = w_opa * w_opb;
    end

    // Align the registered product by whole chunks and accumulate
    assign w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        case (r_puop.shift)
            3'd0:    w_addend = w_prod_ext;
            3'd1:    w_addend = w_prod_ext << CHUNK_W;
            3'd2:    w_addend = w_prod_ext << (2 * CHUNK_W);
            3'd3:    w_addend = w_prod_ext << (3 * CHUNK_W);
            3'd4:    w_addend = w_prod_ext << (4 * CHUNK_W);
            default: w_addend = '0;
        endcase
        n_acc = (r_puop.clr ? '0 : r_acc) + w_addend;
    end

    // Hold the issue flag of the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctrl.issue;
        end
    end

    // Capture vectors, register products, store finished sums
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_px <= i_mom_x;
            r_py <= i_mom_y;
            r_pz <= i_mom_z;
            r_lx <= i_lepton_x;
            r_ly <= i_lepton_y;
            r_lz <= i_lepton_z;
        end
        r_puop <= w_uop;
        r_prod <= w_prod;
        if (r_pvalid) begin
            r_acc <= n_acc;
            case (r_puop.dest)
                DST_DOT: r_dot <= n_acc[DOT_W-1:0];
                DST_PP:  r_pp  <= n_acc[SQ_W-1:0];
                DST_LL:  r_ll  <= n_acc[SQ_W-1:0];
                DST_C2:  r_c2  <= n_acc[C2_W-1:0];
                DST_Q:   r_q   <= n_acc[WIDE_W-1:0];
                DST_LHS: r_lhs <= n_acc[WIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // dot^2 * 2^32 > rhs reduces to a compare on the upper 96 bits
    assign o_angle_ok = r_lhs > r_acc[ACC_W-1:ACC_W-WIDE_W];

endmodule

/* design/chm_seq.sv */
// ---------------------------------------------------------------------------
// chm_seq: request sequencer and event counter
// Matches the particle against the table, steps the multiplier microcode,
// keeps the saturating count and issues the event report.
// ---------------------------------------------------------------------------
module chm_seq #(
    parameter int TABLE_SLOTS = chm_pkg::DEF_TABLE_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  chm_pkg::t_slot                    i_slots [TABLE_SLOTS],
    input  chm_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_has_particle,
    input  logic                              i_last_in_event,
    input  logic signed [chm_pkg::CODE_W-1:0] i_particle_code,
    input  logic [chm_pkg::NRG_W-1:0]         i_total_energy,
    input  logic [chm_pkg::NRG_W-1:0]         i_rest_mass,
    input  logic                              i_angle_ok,
    output chm_pkg::t_dp_ctrl                 o_dp,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_passes,
    output logic [chm_pkg::CNT_W-1:0]         o_multiplicity
);
    import chm_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              r_hit;
    logic              r_last;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic              r_passes;
    logic [CNT_W-1:0]  r_mult;

    logic              w_accept;
    logic              w_match;
    logic [NRG_W-1:0]  w_thr;
    logic              w_kin_ok;
    logic              w_cand;
    logic              w_out_free;
    logic              w_leave;
    logic [CNT_W-1:0]  w_new_count;
    logic              w_pass;

    // Lowest-numbered matching slot supplies the threshold
    always_comb begin
        w_match = 1'b0;
        w_thr   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (i_slots[i].code == i_particle_code) begin
                w_match = 1'b1;
                w_thr   = i_slots[i].thr;
            end
        end
        w_kin_ok = {1'b0, i_total_energy} > ({1'b0, i_rest_mass} + {1'b0, w_thr});
        w_cand   = i_has_particle && (i_particle_code != '0) && w_match && w_kin_ok;
    end

    assign w_accept    = i_valid & o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_leave     = (r_state == S_DONE) && (!r_last || w_out_free);
    assign w_new_count = r_count + CNT_W'(r_hit && (r_count != CNT_SAT));
    assign w_pass      = (w_new_count >= i_cfg.min_count) && (w_new_count <= i_cfg.max_count);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = w_cand ? S_CALC : S_DONE;
            S_CALC:  if (r_step == LAST_STEP) n_state = S_DRAIN;
            S_DRAIN: n_state = S_CMP;
            S_CMP:   n_state = S_DONE;
            S_DONE:  if (w_leave) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready      = 1'b0;
        o_dp.load    = 1'b0;
        o_dp.issue   = 1'b0;
        o_dp.step    = r_step;
        case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_dp.load = i_valid;
            end
            S_CALC:  o_dp.issue = 1'b1;
            default: ;
        endcase
    end

    // Advance the sequencer, keep the count, load the report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_last      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CALC) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (w_accept) begin
                r_hit  <= 1'b0;
                r_last <= i_last_in_event;
            end
            if (r_state == S_CMP) begin
                r_hit <= i_angle_ok;
            end
            if (w_leave && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_leave) begin
                if (r_last) begin
                    r_count <= '0;
                end else begin
                    r_count <= w_new_count;
                end
            end
        end
    end

    // Report payload
    always_ff @(posedge i_clk) begin
        if (w_leave && r_last) begin
            r_passes <= w_pass;
            r_mult   <= w_new_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_passes       = r_passes;
    assign o_multiplicity = r_mult;

endmodule

/* design/charged_hadron_multiplicity_cut_top.sv */
// ---------------------------------------------------------------------------
// charged_hadron_multiplicity_cut_top: per-event charged hadron count cut
// Counts particles that pass the table, kinetic energy and angle tests and
// reports the count window decision on the last request of each event.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one particle request with the event's muon momentum;
//   o_out carries one report (passes, multiplicity) per event, sent after
//   the request flagged last_in_event. Registers are written over the
//   APB-style port while no request is in flight.
// Sequence:
//   A request without a particle, with no matching slot or failing the
//   kinetic test goes from acceptance through the finishing state to idle.
//   A request that reaches the angle test runs 26 microcode steps on the
//   single shared 25x25 multiplier, then an accumulate drain, a compare,
//   the finishing state and the return to idle, where the next request
//   is taken. The report is presented in the cycle the block becomes
//   ready again.
// Reset clears the count, the sequencer and the report valid; the table,
//   cosine limit and minimum reset to zero and the maximum to 255.
// A stalled report is held; the finishing request of the next event waits
//   until the report register is free.
// ---------------------------------------------------------------------------
module charged_hadron_multiplicity_cut_top #(
    parameter int TABLE_SLOTS = chm_pkg::DEF_TABLE_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    chm_in_if.sink                         i_in,
    chm_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [chm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [chm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [chm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import chm_pkg::*;

    t_slot    w_slots [TABLE_SLOTS];
    t_cfg     w_cfg;
    t_dp_ctrl w_dp;
    logic     w_angle_ok;

    // Configuration registers
    chm_regs #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_slots (w_slots),
        .o_cfg   (w_cfg)
    );

    // Sequencer and counter
    chm_seq #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slots         (w_slots),
        .i_cfg           (w_cfg),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_has_particle  (i_in.has_particle),
        .i_last_in_event (i_in.last_in_event),
        .i_particle_code (i_in.particle_code),
        .i_total_energy  (i_in.total_energy),
        .i_rest_mass     (i_in.rest_mass),
        .i_angle_ok      (w_angle_ok),
        .o_dp            (w_dp),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_passes        (o_out.passes),
        .o_multiplicity  (o_out.multiplicity)
    );

    // Shared multiplier datapath
    chm_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_dp),
        .i_mom_x     (i_in.mom_x),
        .i_mom_y     (i_in.mom_y),
        .i_mom_z     (i_in.mom_z),
        .i_lepton_x  (i_in.lepton_x),
        .i_lepton_y  (i_in.lepton_y),
        .i_lepton_z  (i_in.lepton_z),
        .i_cos_limit (w_cfg.cos_limit),
        .o_angle_ok  (w_angle_ok)
    );

endmodule
